// ===== src/assert_macros.svh =====
// assertion macros for the integer field formatter rtl
// no dependencies; the including scope provides clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, switched off while reset is high
`define IFF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, active through reset too
`define IFF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/iff_pkg.sv =====
// shared types, constants and helpers of the integer field formatter
// no dependencies
`timescale 1ns / 1ps

package iff_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int VALUE_BITS_DEF = 64;

   // request beat layout, lowest bit first
   localparam int REQ_W        = 80;
   localparam int OP_LSB       = 0;
   localparam int VALUE_LSB    = 3;
   localparam int WIDE_BIT     = 67;
   localparam int FWIDTH_LSB   = 68;
   localparam int ZPAD_BIT     = 75;
   localparam int LALIGN_BIT   = 76;
   localparam int RSP_W        = 8;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_A_LOWER = 8'h61;
   localparam logic [7:0] CH_A_UPPER = 8'h41;
   localparam logic [3:0] DIGIT_TEN  = 4'd10;

   typedef enum logic [2:0] {
      OP_SDEC = 3'd0,
      OP_UDEC = 3'd1,
      OP_HEXL = 3'd2,
      OP_HEXU = 3'd3,
      OP_PTR  = 3'd4,
      OP_CHAR = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      DIG_HOLD,
      DIG_CLEAR,
      DIG_LOAD,
      DIG_DABBLE,
      DIG_SHIFT
   } dig_cmd_type;

   // decimal digits needed for the largest value of the given bit count
   function automatic int dec_digits(input int bits);
      return ((bits * 1233) >> 12) + 1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
      logic [7:0] res;
      if (d < DIGIT_TEN) begin
         res = CH_ZERO + {4'b0000, d};
      end else begin
         res = (upper ? CH_A_UPPER : CH_A_LOWER) + {4'b0000, d - DIGIT_TEN};
      end
      return res;
   endfunction

endpackage

// ===== src/integer_field_formatter.sv =====
// integer field formatter: one request beat in, the padded ascii field out one char a beat
// sequence: decimal kinds pass through convert, strip, layout and emit; hex and pointer skip
// convert, and char also strips no leading zero digits
// a new request is taken only in idle, once the last character of the previous one is issued
// reset: synchronous, active high; clears the sequencer, the phase and the response valid
`timescale 1ns / 1ps

module integer_field_formatter
   import iff_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // op[2:0], value[66:3], is_wide[67], field_width[74:68], zero_fill[75],
   // flush_left[76], zeros[79:77]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // ch[7:0]
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

`include "assert_macros.svh"

   localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int ND_W       = $clog2(DEC_DIGITS + 1);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int LEN_W      = $clog2(DEC_DIGITS + 4);
   localparam int CMP_W      = (WW > LEN_W) ? WW : LEN_W;
   localparam int BC_W       = $clog2(VALUE_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_LAYOUT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_PAD_LEAD  = 3'd0,
      PH_SIGN      = 3'd1,
      PH_PAD_ZERO  = 3'd2,
      PH_PREFIX0   = 3'd3,
      PH_PREFIX1   = 3'd4,
      PH_DIGITS    = 3'd5,
      PH_PAD_TRAIL = 3'd6,
      PH_DONE      = 3'd7
   } ph_type;

   typedef struct packed {
      logic sign;
      logic zero;
      logic prefix;
      logic trail;
   } ph_act_type;

   function automatic ph_type first_after(input ph_type cur, input ph_act_type a);
      ph_type res;
      if (cur < PH_SIGN && a.sign) begin
         res = PH_SIGN;
      end else if (cur < PH_PAD_ZERO && a.zero) begin
         res = PH_PAD_ZERO;
      end else if (cur < PH_PREFIX0 && a.prefix) begin
         res = PH_PREFIX0;
      end else if (cur == PH_PREFIX0) begin
         res = PH_PREFIX1;
      end else if (cur < PH_DIGITS) begin
         res = PH_DIGITS;
      end else if (cur < PH_PAD_TRAIL && a.trail) begin
         res = PH_PAD_TRAIL;
      end else begin
         res = PH_DONE;
      end
      return res;
   endfunction

   state_type             state_ff, state_in;
   ph_type                phase_ff, phase_in;
   op_type                op_ff, op_in;
   logic                  neg_ff, neg_in;
   logic                  la_ff, la_in;
   logic                  zp_ff, zp_in;
   logic [WW-1:0]         w_ff, w_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic [BC_W-1:0]       bit_ff, bit_in;
   logic [WW-1:0]         pad_ff, pad_in;
   logic                  has_pad_ff, has_pad_in;
   logic                  zfill_ff, zfill_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]            rsp_ch_ff, rsp_ch_in;
   logic                  rsp_last_ff, rsp_last_in;

   // request fields
   logic [2:0]            req_op;
   logic [63:0]           req_value;
   logic                  req_wide;
   logic [6:0]            req_fwidth;
   logic [VALUE_BITS-1:0] arg, amask, neg_mag;
   logic                  sign_bit;

   // layout
   logic [CMP_W-1:0]      len_c, w_ext;
   logic [WW-1:0]         pad_c;
   logic                  zfill_c;
   ph_act_type            act_c, act_r;

   // emission
   dig_cmd_type           dig_cmd;
   logic [3:0]            top_digit;
   logic                  emit_go, ph_end, emit_last, pad_phase;
   logic [7:0]            emit_ch;
   ph_type                nxt;

   assign req_op     = req_tdata[OP_LSB +: 3];
   assign req_value  = req_tdata[VALUE_LSB +: 64];
   assign req_wide   = req_tdata[WIDE_BIT];
   assign req_fwidth = req_tdata[FWIDTH_LSB +: 7];

   assign arg      = req_wide ? req_value[VALUE_BITS-1:0] : VALUE_BITS'(req_value[31:0]);
   assign amask    = req_wide ? {VALUE_BITS{1'b1}} : VALUE_BITS'(32'hFFFF_FFFF);
   assign sign_bit = req_wide ? arg[VALUE_BITS-1] : arg[31];
   assign neg_mag  = (~arg + VALUE_BITS'(1)) & amask;

   iff_digits #(
      .VALUE_BITS (VALUE_BITS)
   ) u_digits (
      .clock      (clock),
      .dig_cmd    (dig_cmd),
      .bit_in     (mag_ff[VALUE_BITS-1]),
      .load_value (mag_in),
      .top_digit  (top_digit)
   );

   always_comb begin
      len_c = CMP_W'(nd_ff) + CMP_W'(neg_ff) + ((op_ff == OP_PTR) ? CMP_W'(2) : CMP_W'(0));
      w_ext = CMP_W'(w_ff);
      pad_c = (op_ff != OP_PTR && w_ext > len_c) ? WW'(w_ext - len_c) : '0;
      zfill_c = !la_ff && (pad_c != '0) && zp_ff && (op_ff != OP_CHAR);
      act_c.sign   = neg_ff;
      act_c.zero   = zfill_c;
      act_c.prefix = (op_ff == OP_PTR);
      act_c.trail  = la_ff && (pad_c != '0);
      act_r.sign   = neg_ff;
      act_r.zero   = zfill_ff;
      act_r.prefix = (op_ff == OP_PTR);
      act_r.trail  = la_ff && has_pad_ff;
   end

   // character of the current phase
   always_comb begin
      emit_ch   = CH_SPACE;
      ph_end    = 1'b1;
      pad_phase = 1'b0;
      unique case (phase_ff)
         PH_PAD_LEAD, PH_PAD_TRAIL: begin
            ph_end    = (pad_ff == WW'(1));
            pad_phase = 1'b1;
         end
         PH_PAD_ZERO: begin
            emit_ch   = CH_ZERO;
            ph_end    = (pad_ff == WW'(1));
            pad_phase = 1'b1;
         end
         PH_SIGN:    emit_ch = CH_MINUS;
         PH_PREFIX0: emit_ch = CH_ZERO;
         PH_PREFIX1: emit_ch = CH_X;
         PH_DIGITS: begin
            if (op_ff == OP_CHAR) begin
               emit_ch = mag_ff[7:0];
            end else begin
               emit_ch = hex_char(top_digit, op_ff == OP_HEXU);
               ph_end  = (nd_ff == ND_W'(1));
            end
         end
         PH_DONE: emit_ch = CH_SPACE;
      endcase
      nxt       = first_after(phase_ff, act_r);
      emit_go   = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);
      emit_last = ph_end && (nxt == PH_DONE);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      neg_in        = neg_ff;
      la_in         = la_ff;
      zp_in         = zp_ff;
      w_in          = w_ff;
      mag_in        = mag_ff;
      nd_in         = nd_ff;
      bit_in        = bit_ff;
      pad_in        = pad_ff;
      has_pad_in    = has_pad_ff;
      zfill_in      = zfill_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_ch_in     = rsp_ch_ff;
      rsp_last_in   = rsp_last_ff;
      dig_cmd       = DIG_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = op_type'(req_op);
               neg_in = 1'b0;
               la_in  = req_tdata[LALIGN_BIT];
               zp_in  = req_tdata[ZPAD_BIT];
               w_in   = (req_fwidth > 7'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(req_fwidth);
               mag_in = arg;
               bit_in = BC_W'(VALUE_BITS - 1);
               unique case (req_op)
                  OP_SDEC: begin
                     neg_in   = sign_bit;
                     mag_in   = sign_bit ? neg_mag : arg;
                     nd_in    = ND_W'(DEC_DIGITS);
                     dig_cmd  = DIG_CLEAR;
                     state_in = ST_CONVERT;
                  end
                  OP_UDEC: begin
                     nd_in    = ND_W'(DEC_DIGITS);
                     dig_cmd  = DIG_CLEAR;
                     state_in = ST_CONVERT;
                  end
                  OP_HEXL, OP_HEXU: begin
                     nd_in    = ND_W'(HEX_DIGITS);
                     dig_cmd  = DIG_LOAD;
                     state_in = ST_STRIP;
                  end
                  OP_PTR: begin
                     mag_in   = req_value[VALUE_BITS-1:0];
                     nd_in    = ND_W'(HEX_DIGITS);
                     dig_cmd  = DIG_LOAD;
                     state_in = ST_STRIP;
                  end
                  OP_CHAR: begin
                     nd_in    = ND_W'(1);
                     state_in = ST_STRIP;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONVERT: begin
            dig_cmd = DIG_DABBLE;
            mag_in  = mag_ff << 1;
            if (bit_ff == '0) begin
               state_in = ST_STRIP;
            end else begin
               bit_in = bit_ff - BC_W'(1);
            end
         end
         ST_STRIP: begin
            if (op_ff != OP_CHAR && top_digit == 4'd0 && nd_ff > ND_W'(1)) begin
               dig_cmd = DIG_SHIFT;
               nd_in   = nd_ff - ND_W'(1);
            end else begin
               state_in = ST_LAYOUT;
            end
         end
         ST_LAYOUT: begin
            pad_in     = pad_c;
            has_pad_in = (pad_c != '0);
            zfill_in   = zfill_c;
            phase_in   = (!zfill_c && !la_ff && pad_c != '0) ? PH_PAD_LEAD
                                                            : first_after(PH_PAD_LEAD, act_c);
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_tvalid_in = 1'b1;
               rsp_ch_in     = emit_ch;
               rsp_last_in   = emit_last;
               if (pad_phase) begin
                  pad_in = pad_ff - WW'(1);
               end
               if (phase_ff == PH_DIGITS && op_ff != OP_CHAR) begin
                  dig_cmd = DIG_SHIFT;
                  nd_in   = nd_ff - ND_W'(1);
               end
               if (ph_end) begin
                  phase_in = nxt;
               end
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      neg_ff     <= neg_in;
      la_ff      <= la_in;
      zp_ff      <= zp_in;
      w_ff       <= w_in;
      mag_ff     <= mag_in;
      nd_ff      <= nd_in;
      bit_ff     <= bit_in;
      pad_ff     <= pad_in;
      has_pad_ff <= has_pad_in;
      zfill_ff   <= zfill_in;
      rsp_ch_ff  <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_DONE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_ch_ff;
   assign rsp_tlast  = rsp_last_ff;

   `IFF_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE && !rsp_tvalid, "reset not idle")
   `IFF_ASSERT(a_last_idles, emit_go && emit_last |=> req_tready && rsp_tlast, "not idle")
   `IFF_ASSERT(a_digits_left, phase_ff == PH_DIGITS |-> nd_ff != '0, "digit count ran out")
   `IFF_ASSERT(a_pad_left, pad_phase |-> pad_ff != '0, "pad count ran out")

endmodule

// ===== src/iff_digits.sv =====
// digit register: bit-serial binary to bcd conversion, hex load and digit shift-out
// depends on iff_pkg
`timescale 1ns / 1ps

module iff_digits
   import iff_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  dig_cmd_type           dig_cmd,
   input  logic                  bit_in,
   input  logic [VALUE_BITS-1:0] load_value,
   output logic [3:0]            top_digit
);

   localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
   localparam int DW         = DEC_DIGITS * 4;
   localparam int HEX_BITS   = ((VALUE_BITS + 3) / 4) * 4;

   logic [DW-1:0] dig_ff, dig_in;
   logic [DW-1:0] adj;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? dig_ff[i*4 +: 4] + 4'd3
                                                    : dig_ff[i*4 +: 4];
      end
   end

   always_comb begin
      unique case (dig_cmd)
         DIG_CLEAR:  dig_in = '0;
         DIG_LOAD:   dig_in = DW'(load_value) << (DW - HEX_BITS);
         DIG_DABBLE: dig_in = {adj[DW-2:0], bit_in};
         DIG_SHIFT:  dig_in = dig_ff << 4;
         default:    dig_in = dig_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
   end

   assign top_digit = dig_ff[DW-1 -: 4];

endmodule
